// ===== rtl/rdq_pkg.sv =====
package rdq_pkg;

    localparam int CAP_DEFAULT = 64;

    localparam int CMD_W   = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int OCC_W   = 7;
    localparam int STAT_W  = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ROT_LEFT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ROT_RIGHT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ       = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic        [CMD_W-1:0]   cmd;
        logic signed [VALUE_W-1:0] value;
        logic        [POS_W-1:0]   position;
    } t_in_beat;

    typedef struct packed {
        logic signed [VALUE_W-1:0] data;
        logic        [OCC_W-1:0]   occupancy;
        logic        [STAT_W-1:0]  status;
    } t_out_beat;

endpackage

// ===== rtl/rotating_deque_unit.sv =====
// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+----------------------------
// command  | in        | i_in_valid / o_in_stall   | i_in_beat  (cmd, value, position)
// result   | out       | o_out_valid / i_out_stall | o_out_beat (data, occupancy, status)
//
// one command at a time: push, dropped push, empty rotate, out-of-range read or spare
// code go from execute straight to the result step, a read adds a read-data step, rotate
// right a write-back step and rotate left a write-back and a front-advance step; the
// next command is taken once the sequencer is back in idle
// the step sequence is set by the single-port store with its registered read and the one
// modular address adder that every step shares
// synchronous active-low reset clears front index, count, sequencer and output valid;
// the store is not cleared
// a stalled result holds in the output register; the next command is taken meanwhile
module rotating_deque_unit
    import rdq_pkg::*;
#(
    parameter int CAPACITY = CAP_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    // sequencer codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_ROT2  = 3'd2;
    localparam logic [2:0] S_ROT3  = 3'd3;
    localparam logic [2:0] S_READ2 = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;

    // latched command beat
    t_in_beat r_cmd_beat;

    // result being assembled
    logic signed [VALUE_W-1:0] r_data, n_data;
    logic [STAT_W-1:0]         r_status, n_status;

    // output register
    logic      r_out_valid;
    t_out_beat r_out_beat;

    // shared address unit
    logic [CW-1:0] au_offset;
    logic [AW-1:0] au_slot;

    // store access
    logic                      mem_we;
    logic                      mem_re;
    logic signed [VALUE_W-1:0] mem_wdata;
    logic signed [VALUE_W-1:0] mem_rdata;

    logic in_take;
    logic out_free;
    logic is_full;
    logic is_empty;
    logic pos_ok;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign is_full  = (r_count == CW'(CAPACITY));
    assign is_empty = (r_count == '0);
    assign pos_ok   = (PW'(r_cmd_beat.position) < PW'(r_count));

    rdq_addr_unit #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .CW    (CW)
    ) u_addr (
        .i_base   (r_front),
        .i_offset (au_offset),
        .o_slot   (au_slot)
    );

    // one port does either a read or a write each cycle, both at the adder's slot
    rdq_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (au_slot),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (au_slot),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_front   = r_front;
        n_count   = r_count;
        n_data    = r_data;
        n_status  = r_status;
        au_offset = '0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_wdata = r_cmd_beat.value;
        case (r_state)
            S_IDLE: begin
                n_data   = '0;
                n_status = ST_OK;
                if (in_take) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_OUT;
                case (r_cmd_beat.cmd)
                    CMD_PUSH_FRONT: begin
                        if (is_full) begin
                            n_status = ST_FULL;
                        end else begin
                            // slot before the front
                            au_offset = CW'(CAPACITY - 1);
                            mem_we    = 1'b1;
                            n_front   = au_slot;
                            n_count   = r_count + 1'b1;
                        end
                    end
                    CMD_PUSH_BACK: begin
                        if (is_full) begin
                            n_status = ST_FULL;
                        end else begin
                            au_offset = r_count;
                            mem_we    = 1'b1;
                            n_count   = r_count + 1'b1;
                        end
                    end
                    CMD_ROT_LEFT: begin
                        if (is_empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            // fetch the front entry
                            au_offset = '0;
                            mem_re    = 1'b1;
                            n_state   = S_ROT2;
                        end
                    end
                    CMD_ROT_RIGHT: begin
                        if (is_empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            // fetch the back entry
                            au_offset = r_count - 1'b1;
                            mem_re    = 1'b1;
                            n_state   = S_ROT2;
                        end
                    end
                    CMD_READ: begin
                        if (pos_ok) begin
                            au_offset = CW'(r_cmd_beat.position);
                            mem_re    = 1'b1;
                            n_state   = S_READ2;
                        end else begin
                            n_status = ST_EMPTY;
                        end
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end
            S_ROT2: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                if (r_cmd_beat.cmd == CMD_ROT_LEFT) begin
                    // front entry goes just past the back; when full this is the front itself
                    au_offset = r_count;
                    n_state   = S_ROT3;
                end else begin
                    // back entry goes just before the front, which becomes the new front
                    au_offset = CW'(CAPACITY - 1);
                    n_front   = au_slot;
                    n_state   = S_OUT;
                end
            end
            S_ROT3: begin
                au_offset = CW'(1);
                n_front   = au_slot;
                n_state   = S_OUT;
            end
            S_READ2: begin
                n_data  = mem_rdata;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_data   <= n_data;
        r_status <= n_status;
        if (in_take) begin
            r_cmd_beat <= i_in_beat;
        end
    end

    // output register: a waiting result parts the result side from the command side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out_beat.data      <= r_data;
            r_out_beat.occupancy <= OCC_W'(r_count);
            r_out_beat.status    <= r_status;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    // count stays within capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count beyond capacity");

    // front index stays inside the store
    a_front_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_front <= AW'(CAPACITY - 1))
        else $error("front index outside the store");

    // count only ever grows by one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_count == $past(r_count) + 1'b1))
        else $error("element count moved by other than one");

    // a result is loaded only out of the result step
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result loaded outside the result step");

    // the store is never read and written in the same cycle
    a_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("store read and written together");

endmodule

// ===== rtl/rdq_store.sv =====
module rdq_store
    import rdq_pkg::*;
#(
    parameter int DEPTH = CAP_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic signed [VALUE_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic signed [VALUE_W-1:0] o_rdata
);

    logic signed [VALUE_W-1:0] r_mem [DEPTH];
    logic signed [VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rdq_addr_unit.sv =====
module rdq_addr_unit
    import rdq_pkg::*;
#(
    parameter int DEPTH = CAP_DEFAULT,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic [AW-1:0] i_base,
    input  logic [CW-1:0] i_offset,
    output logic [AW-1:0] o_slot
);

    // base < DEPTH and offset <= DEPTH, so one conditional subtract wraps it
    logic [CW:0] sum;
    logic [CW:0] wrapped;

    always_comb begin
        sum     = (CW+1)'(i_base) + (CW+1)'(i_offset);
        wrapped = sum - (CW+1)'(DEPTH);
        o_slot  = (sum >= (CW+1)'(DEPTH)) ? AW'(wrapped) : AW'(sum);
    end

endmodule

// ===== bench/rdq_checker.sv =====
`timescale 1ns / 1ps

module rdq_checker
    import rdq_pkg::*;
#(
    parameter int CAPACITY = CAP_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_beat  i_in_beat,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_beat i_out_beat,
    output int        o_error_count,
    output int        o_pending
);

    // shadow of the deque: ring store, front slot and element count
    logic signed [VALUE_W-1:0] ring [CAPACITY];
    int unsigned               head;
    int unsigned               fill;
    t_out_beat                 awaited_results [$];

    // applies one command to the shadow deque and returns the result it owes
    function automatic t_out_beat step_deque(t_in_beat b);
        t_out_beat   r;
        int unsigned back;
        int unsigned prev;
        r = '0;
        case (b.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (fill >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    if (b.cmd == CMD_PUSH_FRONT) begin
                        head = (head + CAPACITY - 1) % CAPACITY;
                        ring[head] = b.value;
                    end else begin
                        ring[(head + fill) % CAPACITY] = b.value;
                    end
                    fill++;
                end
            end
            CMD_ROT_LEFT: begin
                if (fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // when full the write lands on the slot just read
                    ring[(head + fill) % CAPACITY] = ring[head];
                    head = (head + 1) % CAPACITY;
                end
            end
            CMD_ROT_RIGHT: begin
                if (fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    back = (head + fill - 1) % CAPACITY;
                    prev = (head + CAPACITY - 1) % CAPACITY;
                    ring[prev] = ring[back];
                    head = prev;
                end
            end
            CMD_READ: begin
                if (b.position < fill) begin
                    r.data = ring[(head + b.position) % CAPACITY];
                end else begin
                    r.status = ST_EMPTY;
                end
            end
            default: ;
        endcase
        r.occupancy = OCC_W'(fill);
        return r;
    endfunction

    function automatic bit field_ok(string field, logic [VALUE_W-1:0] want,
                                    logic [VALUE_W-1:0] got);
        if (want === got) return 1'b1;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                 $time, field, $signed(want), $signed(got));
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin : compare
        t_out_beat want;
        int        fresh_errors;
        fresh_errors = 0;
        if (!i_rst_n) begin
            head = 0;
            fill = 0;
            awaited_results.delete();
            o_error_count <= 0;
            o_pending     <= 0;
        end else begin
            // retire first: a result never belongs to the command taken at this edge
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %0d/%0d/%0d",
                             $time, i_out_beat.data, i_out_beat.occupancy,
                             i_out_beat.status);
                    fresh_errors++;
                end else begin
                    want = awaited_results.pop_front();
                    if (!field_ok("data", want.data, i_out_beat.data)) fresh_errors++;
                    if (!field_ok("occupancy", VALUE_W'(want.occupancy),
                                  VALUE_W'(i_out_beat.occupancy))) fresh_errors++;
                    if (!field_ok("status", VALUE_W'(want.status),
                                  VALUE_W'(i_out_beat.status))) fresh_errors++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                awaited_results.push_back(step_deque(i_in_beat));
            end
            o_error_count <= o_error_count + fresh_errors;
            o_pending     <= awaited_results.size();
        end
    end

endmodule

// ===== bench/tb_rotating_deque_unit.sv =====
`timescale 1ns / 1ps

module tb_rotating_deque_unit;
    import rdq_pkg::*;

    localparam int CAPACITY     = CAP_DEFAULT;
    localparam int RANDOM_BEATS = 1830;
    // push-light stretch so the deque fills slowly and partial levels get exercised
    localparam int FILL_PHASE   = 950;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 20;

    // command codes the block must ignore
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_MID   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_RUNS,
        STALL_TOGGLE
    } t_stall_mode;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_beat  in_beat   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_beat out_beat;

    int errors;
    int pending;

    // rough element count, only used to steer the command mix and read positions
    int level = 0;
    int burst_left = 0;

    always #1 clk = ~clk;

    rotating_deque_unit #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_beat  (in_beat),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_beat (out_beat)
    );

    rdq_checker #(
        .CAPACITY(CAPACITY)
    ) u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_beat    (in_beat),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_beat   (out_beat),
        .o_error_count(errors),
        .o_pending    (pending)
    );

    // result-side back-pressure: segments of different character, including
    // stretches with no stall at all
    t_stall_mode stall_mode = STALL_NONE;
    int          mode_left  = 0;
    int          run_left   = 0;
    logic        run_hold   = 1'b0;

    always @(negedge clk) begin
        if (mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            mode_left  = $urandom_range(30, 300);
        end
        mode_left--;
        case (stall_mode)
            STALL_NONE: out_stall <= 1'b0;
            STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
            STALL_RUNS: begin
                // long holds broken by short open windows
                if (run_left == 0) begin
                    run_hold = !run_hold;
                    run_left = run_hold ? $urandom_range(1, 12) : $urandom_range(1, 4);
                end
                run_left--;
                out_stall <= run_hold;
            end
            default: out_stall <= !out_stall;
        endcase
    end

    // one command beat: opens a new burst after a random gap when the old one
    // runs out, then holds the beat until the block takes it
    task automatic send_beat(input t_in_beat beat);
        int gap;
        @(negedge clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_beat  <= beat;
        if ((beat.cmd == CMD_PUSH_FRONT || beat.cmd == CMD_PUSH_BACK) && level < CAPACITY) begin
            level++;
        end
        do @(posedge clk); while (in_stall);
    endtask

    function automatic t_in_beat make_beat(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value,
                                           logic [POS_W-1:0] position);
        t_in_beat b;
        b.cmd      = cmd;
        b.value    = value;
        b.position = position;
        return b;
    endfunction

    // random command: pushes are scarce while filling, reads mostly land
    // inside the deque, a few spare codes mixed in as noise
    function automatic t_in_beat pick_beat(bit filling);
        t_in_beat b;
        int       roll;
        int       push_share;
        b.value    = $urandom;
        b.position = POS_W'($urandom);
        if ($urandom_range(0, 15) == 0) begin
            case ($urandom_range(0, 3))
                0: b.value = 32'sh7FFF_FFFF;
                1: b.value = 32'sh8000_0000;
                2: b.value = '0;
                default: b.value = '1;
            endcase
        end
        push_share = filling ? 7 : 20;
        roll = $urandom_range(0, 99);
        if (roll < push_share) begin
            b.cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        end else if (roll < push_share + 18) begin
            b.cmd = CMD_ROT_LEFT;
        end else if (roll < push_share + 36) begin
            b.cmd = CMD_ROT_RIGHT;
        end else if (roll < 98) begin
            b.cmd = CMD_READ;
            if (level > 0 && $urandom_range(0, 3) != 0) begin
                b.position = POS_W'($urandom_range(0, level - 1));
            end
        end else begin
            case ($urandom_range(0, 2))
                0: b.cmd = CMD_SPARE_FIRST;
                1: b.cmd = CMD_SPARE_MID;
                default: b.cmd = CMD_SPARE_LAST;
            endcase
        end
        return b;
    endfunction

    initial begin : stimulus
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // empty deque: read and both rotates must report empty
        send_beat(make_beat(CMD_READ, 32'h1234_5678, '0));
        send_beat(make_beat(CMD_ROT_LEFT, '0, '0));
        send_beat(make_beat(CMD_ROT_RIGHT, '0, '0));
        // spare codes are ignored
        send_beat(make_beat(CMD_SPARE_FIRST, '1, '1));
        send_beat(make_beat(CMD_SPARE_MID, 32'h5555_5555, 6'h2A));
        send_beat(make_beat(CMD_SPARE_LAST, 32'hAAAA_AAAA, 6'h15));
        // value extremes at both ends
        send_beat(make_beat(CMD_PUSH_BACK, 32'h7FFF_FFFF, '0));
        send_beat(make_beat(CMD_PUSH_FRONT, 32'h8000_0000, '1));
        send_beat(make_beat(CMD_PUSH_BACK, '1, '0));
        send_beat(make_beat(CMD_PUSH_FRONT, '0, '0));
        // reads at both ends, just past the count and at the top position
        send_beat(make_beat(CMD_READ, '0, 6'd0));
        send_beat(make_beat(CMD_READ, '0, 6'd3));
        send_beat(make_beat(CMD_READ, '0, 6'd4));
        send_beat(make_beat(CMD_READ, '0, 6'd63));
        // rotate each way and look at both ends again
        send_beat(make_beat(CMD_ROT_LEFT, '0, '0));
        send_beat(make_beat(CMD_READ, '0, 6'd0));
        send_beat(make_beat(CMD_READ, '0, 6'd3));
        send_beat(make_beat(CMD_ROT_RIGHT, '0, '0));
        send_beat(make_beat(CMD_ROT_RIGHT, '0, '0));
        send_beat(make_beat(CMD_READ, '0, 6'd0));
        send_beat(make_beat(CMD_READ, '0, 6'd3));
        send_beat(make_beat(CMD_READ, '0, 6'd2));

        // random traffic; once full the deque stays full, covering dropped
        // pushes and rotates where the write hits the slot it reads
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            send_beat(pick_beat(n < FILL_PHASE));
        end

        @(negedge clk);
        in_valid <= 1'b0;

        // every command owes one result; wait for all of them, then a margin
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog on cycles without any accepted beat on either channel
    int idle_cycles = 0;

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
